/* sv/stt_pkg.sv */
// Shared types and op codes for the segment timeline table.
`default_nettype none

package stt_pkg;

   localparam logic [2:0] OP_APPEND  = 3'd0;
   localparam logic [2:0] OP_MERGE   = 3'd1;
   localparam logic [2:0] OP_TIME_AT = 3'd2;
   localparam logic [2:0] OP_NUM_AT  = 3'd3;
   localparam logic [2:0] OP_AHEAD   = 3'd4;
   localparam logic [2:0] OP_PRUNE   = 3'd5;

   typedef struct packed {
      logic [31:0] first_number;
      logic [62:0] start_time;
      logic [31:0] duration;
      logic [31:0] repeats;
   } run_entry_type;

endpackage

`default_nettype wire

/* sv/segment_timeline_table.sv */
// Segment timeline table: a ring of timeline runs and the ops that use it.
//
// Requests arrive on the req_ channel (valid/ready); each one gives exactly
// one response on the rsp_ channel (valid/ready). One request is processed at
// a time: req_ready is high only while the sequencer is idle.
// Runs live in a single-port-write RAM with a registered read; the
// sequencer reads one run per step, so latency scales with the runs visited:
//   append / merge: the last run at most (merge inside the last run adds the divide)
//   time by number: each run visited; time ahead: the first run, then runs from the last back
//   number by time: each run visited, plus the divide
//   prune: each run removed or trimmed
// The divide is a bit-serial divider (one quotient bit per cycle).
// The response is held in its own register, so a stalled receiver only
// blocks completion of the next request, not its acceptance.
// Reset empties the table at once (run count, head and total length to
// zero); no clearing pass is needed since only occupied slots are read.
`default_nettype none

module segment_timeline_table #(
   parameter int MAX_RUNS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_op,
   input  wire logic [31:0] req_seg_number,
   input  wire logic [31:0] req_seg_duration,
   input  wire logic [31:0] req_repeat_count,
   input  wire logic [62:0] req_start_time,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_found,
   output logic [62:0]      rsp_result_time,
   output logic [31:0]      rsp_result_duration,
   output logic [31:0]      rsp_result_number,
   output logic [31:0]      rsp_pruned_count,
   output logic [62:0]      rsp_timeline_length,
   output logic             rsp_table_full
);
   import stt_pkg::*;

   localparam int SW   = $clog2(MAX_RUNS);
   localparam int CW   = $clog2(MAX_RUNS + 1);
   localparam int SUMW = $clog2(2 * MAX_RUNS);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DISP     = 5'd1;
   localparam logic [4:0] S_FETCH    = 5'd2;
   localparam logic [4:0] S_LOAD     = 5'd3;
   localparam logic [4:0] S_AP_MUL   = 5'd4;
   localparam logic [4:0] S_AP_T     = 5'd5;
   localparam logic [4:0] S_AP_LEN   = 5'd6;
   localparam logic [4:0] S_AP_WR    = 5'd7;
   localparam logic [4:0] S_MG_MUL   = 5'd8;
   localparam logic [4:0] S_MG_CHK   = 5'd9;
   localparam logic [4:0] S_DIV      = 5'd10;
   localparam logic [4:0] S_MG_NR    = 5'd11;
   localparam logic [4:0] S_MG_MUL2  = 5'd12;
   localparam logic [4:0] S_MG_WR    = 5'd13;
   localparam logic [4:0] S_TN_CHK   = 5'd14;
   localparam logic [4:0] S_TN_RES   = 5'd15;
   localparam logic [4:0] S_NT_MUL   = 5'd16;
   localparam logic [4:0] S_NT_CHK   = 5'd17;
   localparam logic [4:0] S_NT_FIN   = 5'd18;
   localparam logic [4:0] S_TA_FIRST = 5'd19;
   localparam logic [4:0] S_TA_LAST  = 5'd20;
   localparam logic [4:0] S_TA_STEP  = 5'd21;
   localparam logic [4:0] S_TA_ACC   = 5'd22;
   localparam logic [4:0] S_PR_TOP   = 5'd23;
   localparam logic [4:0] S_PR_CHK   = 5'd24;
   localparam logic [4:0] S_PR_PART  = 5'd25;
   localparam logic [4:0] S_PR_DROP  = 5'd26;
   localparam logic [4:0] S_DONE     = 5'd27;

   function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] h,
                                             input logic [CW-1:0] i);
      logic [SUMW-1:0] s;
      s = SUMW'(h) + SUMW'(i);
      if (s >= SUMW'(MAX_RUNS)) s = s - SUMW'(MAX_RUNS);
      return s[SW-1:0];
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] b);
      logic [33:0] s;
      s = {2'b00, a} + {1'b0, b};
      return (s[33:32] != 2'b00) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   run_entry_type run_mem [MAX_RUNS];
   run_entry_type rd_data_ff;
   run_entry_type wr_data;
   logic          mem_we;
   logic [SW-1:0] wr_slot;
   logic [SW-1:0] rd_slot;

   logic [4:0]    state_ff, ret_ff;
   logic [CW-1:0] count_ff, idx_ff;
   logic [SW-1:0] head_ff;
   logic [62:0]   len_ff;

   logic [2:0]    op_ff;
   logic [31:0]   num_ff, d_ff, r_ff;
   logic [62:0]   t_ff;

   logic [31:0]   e_first_ff, e_dur_ff, e_rep_ff;
   logic [62:0]   e_start_ff;
   logic [62:0]   span_ff;
   logic [31:0]   prev_last_ff;
   logic          add_dur_ff;

   logic          found_ff, full_ff;
   logic [62:0]   rtime_ff;
   logic [31:0]   rdur_ff, rnum_ff, pruned_ff;

   logic [62:0]   div_q_ff;
   logic [31:0]   div_r_ff;
   logic [5:0]    div_cnt_ff;

   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_p_ff;

   logic          rsp_valid_ff, rsp_found_ff, rsp_full_ff;
   logic [62:0]   rsp_time_ff, rsp_len_ff;
   logic [31:0]   rsp_dur_ff, rsp_num_ff, rsp_pruned_ff;
   logic          rsp_load;

   logic [32:0]   last33;
   logic          num_ge_first, num_le_last;
   logic [31:0]   diff_nf, diff_ln;
   logic [62:0]   span, run_end;
   logic [32:0]   div_sh, div_sub;
   logic          div_ge;
   logic [63:0]   nr_sum;
   logic [31:0]   nr_sat, nr;

   assign last33       = {1'b0, e_first_ff} + {1'b0, e_rep_ff};
   assign num_ge_first = num_ff >= e_first_ff;
   assign num_le_last  = {1'b0, num_ff} <= last33;
   assign diff_nf      = num_ff - e_first_ff;
   assign diff_ln      = last33[31:0] - num_ff;
   // valid whenever the last product was duration * repeats
   assign span         = mul_p_ff[62:0] + {31'd0, e_dur_ff};
   assign run_end      = e_start_ff + span;

   assign div_sh  = {div_r_ff, div_q_ff[62]};
   assign div_ge  = div_sh >= {1'b0, e_dur_ff};
   assign div_sub = div_sh - {1'b0, e_dur_ff};

   assign nr_sum = {1'b0, div_q_ff} + {32'd0, r_ff};
   assign nr_sat = (nr_sum[63:32] != 32'd0) ? 32'hFFFF_FFFF : nr_sum[31:0];
   assign nr     = (nr_sat < e_rep_ff) ? e_rep_ff : nr_sat;

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      mul_a = (state_ff == S_AP_LEN) ? d_ff : e_dur_ff;
      mul_b = e_rep_ff;
      case (state_ff)
         S_AP_LEN:  mul_b = r_ff;
         S_TN_CHK:  mul_b = diff_nf;
         S_TA_STEP: mul_b = (num_ff < e_first_ff) ? e_rep_ff : diff_ln;
         S_PR_CHK:  mul_b = num_le_last ? diff_nf : e_rep_ff;
         default:   mul_b = e_rep_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   assign rd_slot = slot_of(head_ff, idx_ff);

   always_comb begin
      mem_we  = 1'b0;
      wr_slot = rd_slot;
      wr_data = '{first_number: e_first_ff, start_time: e_start_ff,
                  duration: e_dur_ff, repeats: e_rep_ff};
      case (state_ff)
         S_AP_WR: begin
            mem_we  = 1'b1;
            wr_slot = slot_of(head_ff, count_ff);
            wr_data = '{first_number: num_ff, start_time: t_ff,
                        duration: d_ff, repeats: r_ff};
         end
         S_MG_WR: mem_we = 1'b1;
         S_PR_PART: begin
            mem_we  = 1'b1;
            wr_data = '{first_number: num_ff,
                        start_time: e_start_ff + mul_p_ff[62:0],
                        duration: e_dur_ff, repeats: e_rep_ff - diff_nf};
         end
         default: mem_we = 1'b0;
      endcase
   end

   // writes only happen at the end of an op, never to a slot read in flight
   always_ff @(posedge clock) begin
      if (mem_we) run_mem[wr_slot] <= wr_data;
      rd_data_ff <= run_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_op;
                  num_ff   <= req_seg_number;
                  d_ff     <= req_seg_duration;
                  r_ff     <= req_repeat_count;
                  t_ff     <= req_start_time;
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               found_ff  <= 1'b0;
               full_ff   <= (op_ff == OP_APPEND) && (count_ff == CW'(MAX_RUNS));
               rtime_ff  <= '0;
               rdur_ff   <= '0;
               rnum_ff   <= '0;
               pruned_ff <= '0;
               // append and merge start from the last run, lookups from the first
               idx_ff    <= ((op_ff == OP_APPEND || op_ff == OP_MERGE) && count_ff != '0) ?
                            count_ff - CW'(1) : '0;
               case (op_ff)
                  OP_APPEND: begin
                     if (count_ff == CW'(MAX_RUNS)) begin
                        state_ff <= S_DONE;
                     end else if (count_ff != '0 && t_ff == '0) begin
                        ret_ff   <= S_AP_MUL;
                        state_ff <= S_FETCH;
                     end else begin
                        state_ff <= S_AP_LEN;
                     end
                  end
                  OP_MERGE: begin
                     if (count_ff == '0) begin
                        state_ff <= S_AP_LEN;
                     end else begin
                        ret_ff   <= S_MG_MUL;
                        state_ff <= S_FETCH;
                     end
                  end
                  OP_TIME_AT: begin
                     ret_ff   <= S_TN_CHK;
                     state_ff <= (count_ff == '0) ? S_DONE : S_FETCH;
                  end
                  OP_NUM_AT: begin
                     ret_ff   <= S_NT_MUL;
                     state_ff <= (count_ff == '0) ? S_DONE : S_FETCH;
                  end
                  OP_AHEAD: begin
                     ret_ff   <= S_TA_FIRST;
                     state_ff <= (count_ff == '0) ? S_DONE : S_FETCH;
                  end
                  OP_PRUNE: state_ff <= S_PR_TOP;
                  default:  state_ff <= S_DONE;
               endcase
            end
            S_FETCH: state_ff <= S_LOAD;
            S_LOAD: begin
               e_first_ff <= rd_data_ff.first_number;
               e_start_ff <= rd_data_ff.start_time;
               e_dur_ff   <= rd_data_ff.duration;
               e_rep_ff   <= rd_data_ff.repeats;
               state_ff   <= ret_ff;
            end
            S_AP_MUL: state_ff <= S_AP_T;
            S_AP_T: begin
               t_ff     <= run_end;
               state_ff <= S_AP_LEN;
            end
            S_AP_LEN: state_ff <= S_AP_WR;
            S_AP_WR: begin
               len_ff   <= len_ff + mul_p_ff[62:0] + {31'd0, d_ff};
               count_ff <= count_ff + CW'(1);
               state_ff <= S_DONE;
            end
            S_MG_MUL: state_ff <= S_MG_CHK;
            S_MG_CHK: begin
               span_ff <= span;
               if (t_ff >= e_start_ff && t_ff < run_end && e_dur_ff != '0) begin
                  div_q_ff   <= t_ff - e_start_ff;
                  div_r_ff   <= '0;
                  div_cnt_ff <= '0;
                  state_ff   <= S_DIV;
               end else if (t_ff < e_start_ff) begin
                  state_ff <= S_DONE;
               end else if (count_ff == CW'(MAX_RUNS)) begin
                  full_ff  <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  num_ff   <= last33[31:0] + 32'd1;
                  state_ff <= S_AP_LEN;
               end
            end
            S_DIV: begin
               div_r_ff   <= div_ge ? div_sub[31:0] : div_sh[31:0];
               div_q_ff   <= {div_q_ff[61:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == 6'd62)
                  state_ff <= (op_ff == OP_MERGE) ? S_MG_NR : S_NT_FIN;
            end
            S_MG_NR: begin
               e_rep_ff <= nr;
               state_ff <= S_MG_MUL2;
            end
            S_MG_MUL2: state_ff <= S_MG_WR;
            S_MG_WR: begin
               len_ff   <= len_ff - span_ff + span;
               state_ff <= S_DONE;
            end
            S_TN_CHK: begin
               if (num_ge_first && num_le_last) begin
                  found_ff <= 1'b1;
                  rdur_ff  <= e_dur_ff;
                  state_ff <= S_TN_RES;
               end else if (idx_ff + CW'(1) == count_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_FETCH;
               end
            end
            S_TN_RES: begin
               rtime_ff <= e_start_ff + mul_p_ff[62:0];
               state_ff <= S_DONE;
            end
            S_NT_MUL: state_ff <= S_NT_CHK;
            S_NT_CHK: begin
               if (t_ff >= e_start_ff) begin
                  if (t_ff < run_end && e_dur_ff != '0) begin
                     div_q_ff   <= t_ff - e_start_ff;
                     div_r_ff   <= '0;
                     div_cnt_ff <= '0;
                     state_ff   <= S_DIV;
                  end else begin
                     prev_last_ff <= last33[31:0];
                     if (idx_ff + CW'(1) == count_ff) begin
                        rnum_ff  <= last33[31:0];
                        state_ff <= S_DONE;
                     end else begin
                        idx_ff   <= idx_ff + CW'(1);
                        state_ff <= S_FETCH;
                     end
                  end
               end else begin
                  rnum_ff  <= (idx_ff == '0) ? e_first_ff : prev_last_ff;
                  state_ff <= S_DONE;
               end
            end
            S_NT_FIN: begin
               rnum_ff  <= e_first_ff + div_q_ff[31:0];
               state_ff <= S_DONE;
            end
            S_TA_FIRST: begin
               if (!num_ge_first) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff   <= count_ff - CW'(1);
                  ret_ff   <= S_TA_LAST;
                  state_ff <= S_FETCH;
               end
            end
            S_TA_LAST: state_ff <= num_le_last ? S_TA_STEP : S_DONE;
            S_TA_STEP: begin
               if (!num_le_last) begin
                  state_ff <= S_DONE;
               end else begin
                  add_dur_ff <= !num_ge_first;
                  state_ff   <= S_TA_ACC;
               end
            end
            S_TA_ACC: begin
               rtime_ff <= rtime_ff + mul_p_ff[62:0] +
                           (add_dur_ff ? {31'd0, e_dur_ff} : 63'd0);
               if (idx_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff - CW'(1);
                  ret_ff   <= S_TA_STEP;
                  state_ff <= S_FETCH;
               end
            end
            S_PR_TOP: begin
               idx_ff <= '0;
               ret_ff <= S_PR_CHK;
               state_ff <= (count_ff == '0) ? S_DONE : S_FETCH;
            end
            S_PR_CHK: begin
               if (num_ff <= e_first_ff) state_ff <= S_DONE;
               else if (num_le_last)     state_ff <= S_PR_PART;
               else                      state_ff <= S_PR_DROP;
            end
            S_PR_PART: begin
               pruned_ff <= sat_add(pruned_ff, {1'b0, diff_nf});
               len_ff    <= len_ff - mul_p_ff[62:0];
               state_ff  <= S_DONE;
            end
            S_PR_DROP: begin
               pruned_ff <= sat_add(pruned_ff, {1'b0, e_rep_ff} + 33'd1);
               len_ff    <= len_ff - span;
               head_ff   <= slot_of(head_ff, CW'(1));
               count_ff  <= count_ff - CW'(1);
               state_ff  <= S_PR_TOP;
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_found_ff  <= found_ff;
                  rsp_time_ff   <= rtime_ff;
                  rsp_dur_ff    <= rdur_ff;
                  rsp_num_ff    <= rnum_ff;
                  rsp_pruned_ff <= pruned_ff;
                  rsp_len_ff    <= len_ff;
                  rsp_full_ff   <= full_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_result_time     = rsp_time_ff;
   assign rsp_result_duration = rsp_dur_ff;
   assign rsp_result_number   = rsp_num_ff;
   assign rsp_pruned_count    = rsp_pruned_ff;
   assign rsp_timeline_length = rsp_len_ff;
   assign rsp_table_full      = rsp_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RUNS))
      else $error("run count above table size");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_AP_WR && state_ff != S_PR_DROP) |=> $stable(count_ff))
      else $error("run count changed outside append or prune");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_ready) |=> state_ff == S_DONE)
      else $error("response overwritten while stalled");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> e_dur_ff != 32'd0)
      else $error("divide by zero duration");

endmodule

`default_nettype wire

/* tb/segment_timeline_table_tb.sv */
// Self-checking testbench for the segment timeline table: directed and random requests.
`timescale 1ns / 1ps

module segment_timeline_table_tb;
   import stt_pkg::*;

   localparam int RUNS = 16;
   localparam int PEND_DEPTH = 64;
   localparam logic [63:0] T63 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] N32 = 64'hFFFF_FFFF;

   typedef struct {
      bit        found;
      bit [62:0] rtime;
      bit [31:0] rdur;
      bit [31:0] rnum;
      bit [31:0] pruned;
      bit [62:0] tlen;
      bit        full;
   } timeline_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_op = OP_APPEND;
   logic [31:0] req_seg_number = '0;
   logic [31:0] req_seg_duration = 32'd1;
   logic [31:0] req_repeat_count = '0;
   logic [62:0] req_start_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_found;
   logic [62:0] rsp_result_time;
   logic [31:0] rsp_result_duration;
   logic [31:0] rsp_result_number;
   logic [31:0] rsp_pruned_count;
   logic [62:0] rsp_timeline_length;
   logic        rsp_table_full;

   segment_timeline_table #(.MAX_RUNS(RUNS)) u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the run table
   bit [31:0] tl_first[RUNS];
   bit [62:0] tl_start[RUNS];
   bit [31:0] tl_dur[RUNS];
   bit [31:0] tl_rep[RUNS];
   int        tl_count;
   int        tl_head;
   bit [62:0] tl_len;

   // expected responses, in request order
   timeline_rsp_type pending_rsp[PEND_DEPTH];
   int  pend_wr = 0;
   int  pend_rd = 0;
   int  errors = 0;
   int  sent = 0;
   int  received = 0;
   bit  idle_on = 1'b1;

   function automatic int slot(int i);
      return (tl_head + i) % RUNS;
   endfunction

   function automatic logic [63:0] span(int s);
      return (64'(tl_dur[s]) * (64'(tl_rep[s]) + 64'd1)) & T63;
   endfunction

   function automatic logic [63:0] last_number(int s);
      return 64'(tl_first[s]) + 64'(tl_rep[s]);
   endfunction

   function automatic bit add_run(logic [63:0] num, logic [63:0] d, logic [63:0] r,
                                  logic [63:0] t);
      int s;
      if (tl_count >= RUNS) return 1'b0;
      s = slot(tl_count);
      tl_first[s] = num[31:0];
      tl_dur[s]   = d[31:0];
      tl_rep[s]   = r[31:0];
      tl_start[s] = t[62:0];
      tl_count++;
      return 1'b1;
   endfunction

   function automatic timeline_rsp_type apply_timeline_op(logic [2:0] op, logic [31:0] num_in,
         logic [31:0] d_in, logic [31:0] r_in, logic [62:0] t_in);
      timeline_rsp_type e;
      logic [63:0] num, d, r, t, lt, tend, cnt, nr, sum, pr, grow;
      int s;
      bit done;
      e = '{default: 0};
      num = 64'(num_in); d = 64'(d_in); r = 64'(r_in); t = 64'(t_in);
      pr = 0;
      grow = (d * (r + 64'd1)) & T63;
      case (op)
         OP_APPEND: begin
            if (tl_count > 0 && t == 0) begin
               s = slot(tl_count - 1);
               t = (64'(tl_start[s]) + span(s)) & T63;
            end
            if (add_run(num, d, r, t)) tl_len = 63'((64'(tl_len) + grow) & T63);
            else e.full = 1'b1;
         end
         OP_MERGE: begin
            if (tl_count == 0) begin
               void'(add_run(num, d, r, t));
               tl_len = 63'((64'(tl_len) + grow) & T63);
            end else begin
               s = slot(tl_count - 1);
               lt = 64'(tl_start[s]);
               tend = (lt + span(s)) & T63;
               if (t >= lt && t < tend && tl_dur[s] != 0) begin
                  cnt = (t - lt) / 64'(tl_dur[s]);
                  nr = r + cnt;
                  if (nr > N32) nr = N32;
                  if (nr < 64'(tl_rep[s])) nr = 64'(tl_rep[s]);
                  tl_len = 63'((64'(tl_len) - span(s)) & T63);
                  tl_rep[s] = nr[31:0];
                  tl_len = 63'((64'(tl_len) + span(s)) & T63);
               end else if (t >= lt) begin
                  if (add_run(last_number(s) + 64'd1, d, r, t))
                     tl_len = 63'((64'(tl_len) + grow) & T63);
                  else e.full = 1'b1;
               end
            end
         end
         OP_TIME_AT: begin
            for (int i = 0; i < tl_count; i++) begin
               s = slot(i);
               if (num >= 64'(tl_first[s]) && num <= last_number(s)) begin
                  e.found = 1'b1;
                  e.rtime = 63'((64'(tl_start[s]) + 64'(tl_dur[s]) * (num - 64'(tl_first[s])))
                                & T63);
                  e.rdur = tl_dur[s];
                  break;
               end
            end
         end
         OP_NUM_AT: begin
            if (tl_count > 0) begin
               done = 1'b0;
               for (int i = 0; i < tl_count && !done; i++) begin
                  s = slot(i);
                  if (t >= 64'(tl_start[s])) begin
                     tend = (64'(tl_start[s]) + span(s)) & T63;
                     if (t < tend && tl_dur[s] != 0) begin
                        e.rnum = 32'(64'(tl_first[s]) + (t - 64'(tl_start[s])) / 64'(tl_dur[s]));
                        done = 1'b1;
                     end
                  end else begin
                     e.rnum = (i > 0) ? 32'(last_number(slot(i - 1))) : tl_first[s];
                     done = 1'b1;
                  end
               end
               if (!done) e.rnum = 32'(last_number(slot(tl_count - 1)));
            end
         end
         OP_AHEAD: begin
            if (tl_count > 0 && 64'(tl_first[slot(0)]) <= num &&
                last_number(slot(tl_count - 1)) >= num) begin
               sum = 0;
               for (int i = tl_count; i > 0; i--) begin
                  s = slot(i - 1);
                  if (num > last_number(s)) break;
                  else if (num < 64'(tl_first[s])) sum += span(s);
                  else sum += 64'(tl_dur[s]) * (last_number(s) - num);
                  sum &= T63;
               end
               e.rtime = sum[62:0];
            end
         end
         OP_PRUNE: begin
            while (tl_count > 0) begin
               s = slot(0);
               if (64'(tl_first[s]) >= num) break;
               else if (last_number(s) >= num) begin
                  cnt = num - 64'(tl_first[s]);
                  tl_first[s] = num[31:0];
                  tl_start[s] = 63'((64'(tl_start[s]) + cnt * 64'(tl_dur[s])) & T63);
                  tl_rep[s] = tl_rep[s] - cnt[31:0];
                  pr += cnt;
                  tl_len = 63'((64'(tl_len) - ((cnt * 64'(tl_dur[s])) & T63)) & T63);
                  break;
               end else begin
                  pr += 64'(tl_rep[s]) + 64'd1;
                  tl_len = 63'((64'(tl_len) - span(s)) & T63);
                  tl_head = (tl_head + 1) % RUNS;
                  tl_count--;
               end
            end
            e.pruned = (pr > N32) ? 32'hFFFF_FFFF : pr[31:0];
         end
         default: ;
      endcase
      e.tlen = tl_len;
      return e;
   endfunction

   task automatic send_req(logic [2:0] op, logic [31:0] num, logic [31:0] d,
                           logic [31:0] r, logic [62:0] t);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_seg_number = num;
      req_seg_duration = d;
      req_repeat_count = r;
      req_start_time = t;
      do @(posedge clock); while (!req_ready);
      pending_rsp[pend_wr % PEND_DEPTH] = apply_timeline_op(op, num, d, r, t);
      pend_wr++;
      sent++;
      @(negedge clock);
   endtask

   task automatic drain_rsp();
      req_valid = 1'b0;
      wait (pend_wr == pend_rd);
      repeat (200) @(negedge clock);
   endtask

   // Receiver stalls in bursts
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      timeline_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         received++;
         if (pend_wr == pend_rd) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            e = pending_rsp[pend_rd % PEND_DEPTH];
            pend_rd++;
            check_field("found", 64'(e.found), 64'(rsp_found));
            check_field("result_time", 64'(e.rtime), 64'(rsp_result_time));
            check_field("result_duration", 64'(e.rdur), 64'(rsp_result_duration));
            check_field("result_number", 64'(e.rnum), 64'(rsp_result_number));
            check_field("pruned_count", 64'(e.pruned), 64'(rsp_pruned_count));
            check_field("timeline_length", 64'(e.tlen), 64'(rsp_timeline_length));
            check_field("table_full", 64'(e.full), 64'(rsp_table_full));
         end
      end
   end

   function automatic logic [62:0] rand63();
      return 63'({$urandom, $urandom});
   endfunction

   task automatic test_empty_and_extremes();
      send_req(OP_NUM_AT, 0, 1, 0, 63'd5);
      send_req(OP_AHEAD, 0, 1, 0, 0);
      send_req(OP_TIME_AT, 32'd7, 1, 0, 0);
      send_req(OP_PRUNE, 32'd10, 1, 0, 0);
      send_req(OP_MERGE, 32'd100, 32'd10, 32'd4, 63'd1000);      // merge into empty
      send_req(OP_APPEND, 32'd200, 32'd20, 32'd2, 63'd0);        // derived start
      send_req(OP_MERGE, 0, 32'd20, 32'd5, 63'd1070);            // inside last run
      send_req(OP_MERGE, 0, 32'd20, 32'd1, 63'd10);              // older, ignored
      send_req(OP_MERGE, 0, 32'd30, 32'd1, 63'd5000);            // after last run
      send_req(OP_TIME_AT, 32'd102, 1, 0, 0);
      send_req(OP_TIME_AT, 32'd150, 1, 0, 0);                    // miss
      send_req(OP_NUM_AT, 0, 1, 0, 63'd500);                     // before first run
      send_req(OP_NUM_AT, 0, 1, 0, 63'd1055);                    // inside a run
      send_req(OP_NUM_AT, 0, 1, 0, 63'd4000);                    // gap
      send_req(OP_NUM_AT, 0, 1, 0, 63'h7FFF_FFFF_FFFF_FFFF);     // past the end
      send_req(OP_AHEAD, 32'd103, 1, 0, 0);
      send_req(OP_AHEAD, 32'd99, 1, 0, 0);
      send_req(OP_PRUNE, 32'd103, 1, 0, 0);                      // partial trim
      send_req(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               63'h7FFF_FFFF_FFFF_FFFF);
      send_req(OP_AHEAD, 32'hFFFF_FFFF, 1, 0, 0);
      send_req(OP_TIME_AT, 32'hFFFF_FFFF, 1, 0, 0);
      send_req(OP_MERGE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFE);
      send_req(OP_PRUNE, 32'hFFFF_FFFF, 1, 0, 0);
      send_req(OP_PRUNE, 32'hFFFF_FFFF, 1, 0, 0);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < RUNS + 2; i++)
         send_req(OP_APPEND, 32'(i * 8), 32'd5, 32'd3, 63'd0);
      send_req(OP_MERGE, 0, 32'd5, 32'd1, 63'h0FFF_FFFF);        // would add, table full
      send_req(OP_PRUNE, 32'hFFFF_FFFF, 1, 0, 0);
   endtask

   task automatic test_random(int n_items);
      logic [2:0]  op;
      logic [31:0] num, d, r;
      logic [62:0] t;
      int          s, pick;
      for (int k = 0; k < n_items; k++) begin
         if (k == n_items / 2) drain_rsp();   // sender holds until all responses are in
         if (k == n_items - 100) idle_on = 1'b0;
         pick = $urandom_range(0, 99);
         d = $urandom_range(1, 1000);
         r = $urandom_range(0, 20);
         num = $urandom_range(0, 5000);
         t = 0;
         s = (tl_count > 0) ? slot($urandom_range(0, tl_count - 1)) : 0;
         if (pick < 10) begin
            op = 3'($urandom_range(0, 5));
            num = $urandom;
            d = $urandom;
            if (d == 0) d = 1;
            r = $urandom;
            t = rand63();
         end else if (pick < 35) begin
            op = OP_APPEND;
            if (tl_count > 0) num = 32'(last_number(slot(tl_count - 1)) + 1);
            if ($urandom_range(0, 3) == 0) t = 63'($urandom_range(0, 100000));
         end else if (pick < 50) begin
            op = OP_MERGE;
            if (tl_count > 0) begin
               s = slot(tl_count - 1);
               t = tl_start[s] + 63'($urandom_range(0, 25000));
               if ($urandom_range(0, 7) == 0) t = tl_start[s] - 63'($urandom_range(1, 50));
            end else t = 63'($urandom_range(0, 100000));
         end else if (pick < 88) begin
            op = (pick < 63) ? OP_TIME_AT : (pick < 76) ? OP_NUM_AT : OP_AHEAD;
            if (tl_count > 0) begin
               num = tl_first[s] + $urandom_range(0, 22);
               t = tl_start[s] + 63'($urandom_range(0, 25000));
               if ($urandom_range(0, 5) == 0) t = tl_start[s] - 63'($urandom_range(1, 50));
            end
         end else begin
            op = OP_PRUNE;
            if (tl_count > 0) num = tl_first[slot(0)] + $urandom_range(0, 40);
            if ($urandom_range(0, 5) == 0) num = $urandom;
         end
         if (tl_count >= RUNS - 2 && $urandom_range(0, 2) == 0) begin
            op = OP_PRUNE;
            num = tl_first[slot(tl_count / 2)];
         end
         send_req(op, num, d, r, t);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_and_extremes();
      test_table_full();
      test_random(750);
      drain_rsp();
      $display("Sent %0d requests over all ops, empty and full table and wrap extremes;",
               sent);
      $display("checked %0d responses under random stalls on both sides", received);
      if (errors == 0 && pend_wr == pend_rd) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out waiting for the block");
      $display("Verification failed");
      $finish;
   end

endmodule
